// ===== src/nmt_pkg.sv =====
`default_nettype none

package nmt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [15:0] FIRST_PORT_RESET = 16'd5000;

    // config register map: index = paddr[2]
    localparam int  PADDR_W        = 3;
    localparam logic CFG_EXT_ADDR   = 1'b0;
    localparam logic CFG_FIRST_PORT = 1'b1;

    typedef enum logic [1:0] {
        REQ_INSERT     = 2'd0,
        REQ_LOOKUP_IN  = 2'd1,
        REQ_LOOKUP_OUT = 2'd2
    } req_e_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_e_t;

    typedef struct packed {
        logic [31:0] inside_address;
        logic [15:0] inside_port;
        logic [31:0] outside_address;
        logic [15:0] outside_port;
        logic        kind;
    } entry_t;

    typedef struct packed {
        logic   found;
        logic   table_full;
        entry_t entry;
    } result_t;

    typedef struct packed {
        logic [31:0] external_address;
        logic [15:0] first_port;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] inside_address;
        logic [15:0] inside_port;
        logic [15:0] outside_port;
        logic        kind;
    } key_t;

endpackage

`default_nettype wire

// ===== src/nmt_entry_ram.sv =====
`default_nettype none

module nmt_entry_ram (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [nmt_pkg::IDX_W-1:0]  wr_addr,
    input  wire nmt_pkg::entry_t            wr_data,
    input  wire logic                       rd_en,
    input  wire logic [nmt_pkg::IDX_W-1:0]  rd_addr,
    output nmt_pkg::entry_t                 rd_data
);

    nmt_pkg::entry_t mem [nmt_pkg::TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/nmt_seq.sv =====
`default_nettype none

module nmt_seq (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire nmt_pkg::cfg_t              cfg,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire nmt_pkg::key_t              in_key,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output nmt_pkg::result_t                out_res,
    output logic                            wr_en,
    output logic [nmt_pkg::IDX_W-1:0]       wr_addr,
    output nmt_pkg::entry_t                 wr_data,
    output logic                            rd_en,
    output logic [nmt_pkg::IDX_W-1:0]       rd_addr,
    input  wire nmt_pkg::entry_t            rd_data
);

    nmt_pkg::state_e_t            state_reg, state_next;
    logic [nmt_pkg::CNT_W-1:0]    used_count_reg, used_count_next;
    logic [15:0]                  port_offset_reg, port_offset_next;
    logic [nmt_pkg::CNT_W-1:0]    issue_left_reg, issue_left_next;
    logic                         pend_reg, pend_next;
    logic                         out_valid_reg, out_valid_next;
    nmt_pkg::key_t                key_reg, key_next;
    nmt_pkg::result_t             res_reg, res_next;
    nmt_pkg::result_t             out_res_reg, out_res_next;

    logic                         out_free;
    logic                         table_is_full;
    logic                         match;
    logic                         hit;
    logic                         is_lookup;
    nmt_pkg::entry_t              new_entry;

    assign in_stall  = (state_reg != nmt_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign table_is_full = (used_count_reg == nmt_pkg::CNT_W'(nmt_pkg::TABLE_ENTRIES));
    assign is_lookup = (nmt_pkg::req_e_t'(in_key.req) == nmt_pkg::REQ_LOOKUP_IN) ||
                       (nmt_pkg::req_e_t'(in_key.req) == nmt_pkg::REQ_LOOKUP_OUT);

    // shared compare against the entry read last cycle
    always_comb
    begin
        if (nmt_pkg::req_e_t'(key_reg.req) == nmt_pkg::REQ_LOOKUP_IN)
        begin
            match = (rd_data.inside_address == key_reg.inside_address) &&
                    (rd_data.inside_port == key_reg.inside_port) &&
                    (rd_data.kind == key_reg.kind);
        end
        else
        begin
            match = (rd_data.outside_port == key_reg.outside_port) &&
                    (rd_data.kind == key_reg.kind);
        end
    end

    assign hit = pend_reg && match;

    always_comb
    begin
        new_entry.inside_address  = in_key.inside_address;
        new_entry.inside_port     = in_key.inside_port;
        new_entry.outside_address = cfg.external_address;
        new_entry.outside_port    = 16'(cfg.first_port + port_offset_reg);
        new_entry.kind            = in_key.kind;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nmt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (is_lookup && (used_count_reg != '0))
                    begin
                        state_next = nmt_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = nmt_pkg::ST_FINISH;
                    end
                end
            end
            nmt_pkg::ST_SCAN:
            begin
                if (hit || (issue_left_reg == '0))
                begin
                    state_next = nmt_pkg::ST_FINISH;
                end
            end
            nmt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = nmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nmt_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        used_count_next  = used_count_reg;
        port_offset_next = port_offset_reg;
        issue_left_next  = issue_left_reg;
        pend_next        = 1'b0;
        key_next         = key_reg;
        res_next         = res_reg;
        out_res_next     = out_res_reg;
        out_valid_next   = out_valid_reg;
        wr_en            = 1'b0;
        wr_addr          = used_count_reg[nmt_pkg::IDX_W-1:0];
        wr_data          = new_entry;
        rd_en            = 1'b0;
        rd_addr          = nmt_pkg::IDX_W'(issue_left_reg - nmt_pkg::CNT_W'(1));

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            nmt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next        = in_key;
                    res_next        = '0;
                    issue_left_next = used_count_reg;
                    case (nmt_pkg::req_e_t'(in_key.req))
                        nmt_pkg::REQ_INSERT:
                        begin
                            if (table_is_full)
                            begin
                                res_next.table_full = 1'b1;
                            end
                            else
                            begin
                                wr_en             = 1'b1;
                                res_next.found    = 1'b1;
                                res_next.entry    = new_entry;
                                used_count_next   = used_count_reg + nmt_pkg::CNT_W'(1);
                                port_offset_next  = port_offset_reg + 16'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            nmt_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    res_next.found = 1'b1;
                    res_next.entry = rd_data;
                end
                else if (issue_left_reg != '0)
                begin
                    rd_en           = 1'b1;
                    issue_left_next = issue_left_reg - nmt_pkg::CNT_W'(1);
                    pend_next       = 1'b1;
                end
            end
            nmt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_res_next   = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= nmt_pkg::ST_IDLE;
            used_count_reg  <= '0;
            port_offset_reg <= '0;
            issue_left_reg  <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            used_count_reg  <= used_count_next;
            port_offset_reg <= port_offset_next;
            issue_left_reg  <= issue_left_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        res_reg     <= res_next;
        out_res_reg <= out_res_next;
    end

endmodule

`default_nettype wire

// ===== src/nat_mapping_table.sv =====
`default_nettype none

// NAT translation table, 64 entries. An insert appends the entry with the
// configured external address and port first_port + offset, and answers
// without a scan. A lookup reads the entry RAM one entry per cycle through
// its single read port, newest first, compares each in one shared compare
// unit, and answers on a hit or once all used entries are read; an empty
// table is not scanned. One item is worked on at a time; in_stall is high
// from accept until the result moves to the output register, which may
// still hold an earlier unclaimed result.
module nat_mapping_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [nmt_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   req_type,
    input  wire logic [31:0]                  inside_address,
    input  wire logic [15:0]                  inside_port,
    input  wire logic [15:0]                  outside_port,
    input  wire logic                         proto_kind,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              found,
    output logic                              table_full,
    output logic [31:0]                       entry_inside_address,
    output logic [15:0]                       entry_inside_port,
    output logic [31:0]                       entry_outside_address,
    output logic [15:0]                       entry_outside_port,
    output logic                              entry_kind
);

    logic [31:0]               external_address_reg;
    logic [15:0]               first_port_reg;
    logic                      cfg_wr;
    nmt_pkg::cfg_t             cfg;
    nmt_pkg::key_t             in_key;
    nmt_pkg::result_t          out_res;
    logic                      wr_en;
    logic [nmt_pkg::IDX_W-1:0] wr_addr;
    nmt_pkg::entry_t           wr_data;
    logic                      rd_en;
    logic [nmt_pkg::IDX_W-1:0] rd_addr;
    nmt_pkg::entry_t           rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            external_address_reg <= '0;
            first_port_reg       <= nmt_pkg::FIRST_PORT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                nmt_pkg::CFG_EXT_ADDR:   external_address_reg <= pwdata;
                nmt_pkg::CFG_FIRST_PORT: first_port_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            nmt_pkg::CFG_EXT_ADDR:   prdata = external_address_reg;
            nmt_pkg::CFG_FIRST_PORT: prdata = {16'd0, first_port_reg};
            default:                 prdata = '0;
        endcase
    end

    assign cfg.external_address = external_address_reg;
    assign cfg.first_port       = first_port_reg;

    assign in_key.req            = req_type;
    assign in_key.inside_address = inside_address;
    assign in_key.inside_port    = inside_port;
    assign in_key.outside_port   = outside_port;
    assign in_key.kind           = proto_kind;

    nmt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_key    (in_key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    nmt_entry_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign found                 = out_res.found;
    assign table_full            = out_res.table_full;
    assign entry_inside_address  = out_res.entry.inside_address;
    assign entry_inside_port     = out_res.entry.inside_port;
    assign entry_outside_address = out_res.entry.outside_address;
    assign entry_outside_port    = out_res.entry.outside_port;
    assign entry_kind            = out_res.entry.kind;

endmodule

`default_nettype wire
